/* rtl/dcpd_pkg.sv */
// Package of the debounced color pixel detector: constants, types and helper functions.
package dcpd_pkg;

   // Default frame geometry of the LED wall.
   localparam int DCPD_FRAME_WIDTH  = 20;
   localparam int DCPD_FRAME_HEIGHT = 20;

   // Field widths of the words on the channels.
   localparam int HUE_W    = 8;
   localparam int CHAN_W   = 8;
   localparam int COORD_W  = 5;
   localparam int LIMIT_W  = 4;
   localparam int REPORT_W = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HUE_LOW_A      = 4'd0,
      CSR_HUE_HIGH_A     = 4'd1,
      CSR_HUE_LOW_B      = 4'd2,
      CSR_HUE_HIGH_B     = 4'd3,
      CSR_SAT_MIN        = 4'd4,
      CSR_VAL_MIN        = 4'd5,
      CSR_DEBOUNCE_LIMIT = 4'd6,
      CSR_MAX_REPORTS    = 4'd7
   } csr_index_type;

   // Register values after reset.
   localparam logic [HUE_W-1:0]    RST_HUE_LOW_A      = 8'd0;
   localparam logic [HUE_W-1:0]    RST_HUE_HIGH_A     = 8'd10;
   localparam logic [HUE_W-1:0]    RST_HUE_LOW_B      = 8'd160;
   localparam logic [HUE_W-1:0]    RST_HUE_HIGH_B     = 8'd180;
   localparam logic [CHAN_W-1:0]   RST_SAT_MIN        = 8'd200;
   localparam logic [CHAN_W-1:0]   RST_VAL_MIN        = 8'd200;
   localparam logic [LIMIT_W-1:0]  RST_DEBOUNCE_LIMIT = 4'd3;
   localparam logic [REPORT_W-1:0] RST_MAX_REPORTS    = 6'd10;

   typedef struct packed {
      logic [HUE_W-1:0]    hue_low_a;
      logic [HUE_W-1:0]    hue_high_a;
      logic [HUE_W-1:0]    hue_low_b;
      logic [HUE_W-1:0]    hue_high_b;
      logic [CHAN_W-1:0]   sat_min;
      logic [CHAN_W-1:0]   val_min;
      logic [LIMIT_W-1:0]  debounce_limit;
      logic [REPORT_W-1:0] max_reports;
   } dcpd_cfg_type;

   // One entry of the per-pixel store.
   typedef struct packed {
      logic               flag;
      logic [LIMIT_W-1:0] count;
   } dcpd_entry_type;

   localparam int ENTRY_W = $bits(dcpd_entry_type);

   // True when the pixel passes the saturation, brightness and hue tests.
   function automatic logic dcpd_match(input logic [HUE_W-1:0]  hue,
                                       input logic [CHAN_W-1:0] sat,
                                       input logic [CHAN_W-1:0] val,
                                       input dcpd_cfg_type      cfg);
      logic in_a;
      logic in_b;
      in_a = (hue >= cfg.hue_low_a) && (hue <= cfg.hue_high_a);
      in_b = (hue >= cfg.hue_low_b) && (hue <= cfg.hue_high_b);
      return (sat >= cfg.sat_min) && (val >= cfg.val_min) && (in_a || in_b);
   endfunction

   // Debounce step: count up on a match and cap at the limit, count down on a miss
   // and clear the flag when the count bottoms out.
   function automatic dcpd_entry_type dcpd_update(input dcpd_entry_type     cur,
                                                  input logic               hit,
                                                  input logic [LIMIT_W-1:0] limit);
      dcpd_entry_type    nxt;
      logic [LIMIT_W:0]  inc;
      nxt = cur;
      inc = {1'b0, cur.count} + {{LIMIT_W{1'b0}}, 1'b1};
      if (hit) begin
         if (inc >= {1'b0, limit}) begin
            nxt.flag  = 1'b1;
            nxt.count = limit;
         end else begin
            nxt.count = inc[LIMIT_W-1:0];
         end
      end else begin
         if (cur.count <= {{(LIMIT_W-1){1'b0}}, 1'b1}) begin
            nxt.flag  = 1'b0;
            nxt.count = '0;
         end else begin
            nxt.count = cur.count - {{(LIMIT_W-1){1'b0}}, 1'b1};
         end
      end
      return nxt;
   endfunction

endpackage

/* rtl/dcpd_if.sv */
// Channel interfaces of the debounced color pixel detector: pixel input, report output, register write.
interface dcpd_req_if;
   import dcpd_pkg::*;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [CHAN_W-1:0] saturation;
   logic [CHAN_W-1:0] brightness;
   logic              frame_end;
   modport source (output valid, hue, saturation, brightness, frame_end, input ready);
   modport sink   (input valid, hue, saturation, brightness, frame_end, output ready);
endinterface

interface dcpd_rsp_if;
   import dcpd_pkg::*;
   logic                valid;
   logic                ready;
   logic [COORD_W-1:0]  pixel_col;
   logic [COORD_W-1:0]  pixel_row;
   logic [REPORT_W-1:0] report_number;
   modport source (output valid, pixel_col, pixel_row, report_number, input ready);
   modport sink   (input valid, pixel_col, pixel_row, report_number, output ready);
endinterface

interface dcpd_csr_if;
   import dcpd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/debounced_color_pixel_detector_top.sv */
// Top level of the debounced color pixel detector: position tracking, debounce pipeline, reports.
//
// The block takes one HSV pixel word per cycle in raster order and keeps, for every pixel
// position of the FRAME_WIDTH x FRAME_HEIGHT frame, a debounce counter and a flag in one
// on-chip memory with a registered read. When a pixel word is accepted, its entry is
// read at that edge and the pixel enters the update stage; when that stage moves on, the
// entry is updated and written back, and a report word (column, row, report number) goes
// to an output register; unless stalled, a new pixel is accepted every cycle. When two
// pixels in a row hit the same entry (a frame of one pixel, or frame_end on the first
// position), the word just written is forwarded into the update. Back-pressure on the
// report side stalls the input only while a report is waiting and the update stage is
// full. After reset the memory is cleared one entry per cycle; no pixel is accepted
// during that pass, but register writes are. Registers should be written only while no
// pixel is in flight. At most max_reports reports are made per frame; the count restarts
// on frame_end.
module debounced_color_pixel_detector_top #(
   parameter int FRAME_WIDTH  = dcpd_pkg::DCPD_FRAME_WIDTH,
   parameter int FRAME_HEIGHT = dcpd_pkg::DCPD_FRAME_HEIGHT
) (
   input logic      clock,
   input logic      reset,
   dcpd_req_if.sink   req_port,
   dcpd_rsp_if.source rsp_port,
   dcpd_csr_if.sink   csr_port
);
   import dcpd_pkg::*;

   localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int COL_W     = $clog2(FRAME_WIDTH + 1);
   localparam int ROW_W     = $clog2(FRAME_HEIGHT + 1);
   localparam int ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(FRAME_WIDTH - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(FRAME_HEIGHT - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX_COUNT - 1);

   // Clearing pass after reset, then normal operation.
   typedef enum logic [1:0] {
      ST_CLEAR = 2'b01,
      ST_RUN   = 2'b10
   } state_type;

   dcpd_cfg_type cfg;

   state_type   state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Raster position of the next pixel to be accepted.
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // Update stage: pixel whose memory entry is being read back.
   logic              s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_hit_ff;
   logic              s1_last_ff;

   // Forwarding of the entry written at the edge this stage's entry was read.
   logic              byp_valid_ff, byp_valid_in;
   dcpd_entry_type    byp_data_ff;

   logic [REPORT_W-1:0] reports_ff, reports_in;

   // Output register of the report channel.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]  rsp_col_ff;
   logic [COORD_W-1:0]  rsp_row_ff;
   logic [REPORT_W-1:0] rsp_num_ff;

   logic              req_fire;
   logic              s1_fire;
   logic              report;
   dcpd_entry_type    rd_entry;
   dcpd_entry_type    cur_entry;
   dcpd_entry_type    new_entry;
   logic [ENTRY_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   dcpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   dcpd_ram #(
      .DEPTH  (PIX_COUNT),
      .DATA_W (ENTRY_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // Handshakes. The update stage moves on whenever the output register is free or
   // being emptied; a new pixel enters when the update stage is empty or moving on.
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_port.ready);
   assign req_port.ready = (state_ff == ST_RUN) && (!s1_valid_ff || s1_fire);
   assign req_fire       = req_port.valid && req_port.ready;

   // Debounce update of the entry read for the pixel in the update stage.
   assign rd_entry  = dcpd_entry_type'(rd_data);
   assign cur_entry = byp_valid_ff ? byp_data_ff : rd_entry;
   assign new_entry = dcpd_update(cur_entry, s1_hit_ff, cfg.debounce_limit);
   assign report    = new_entry.flag && (reports_ff < cfg.max_reports);

   // The clearing pass owns the write port until it is done.
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = s1_fire;
         wr_addr = s1_addr_ff;
         wr_data = new_entry;
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN:  state_in = ST_RUN;
         default: state_in = ST_CLEAR;
      endcase
   end

   // Raster position: frame_end or the last position of the frame returns it home.
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      addr_in = addr_ff;
      if (req_fire) begin
         if (req_port.frame_end) begin
            col_in  = '0;
            row_in  = '0;
            addr_in = '0;
         end else if (col_ff == LAST_COL) begin
            col_in = '0;
            if (row_ff == LAST_ROW) begin
               row_in  = '0;
               addr_in = '0;
            end else begin
               row_in  = row_ff + {{(ROW_W-1){1'b0}}, 1'b1};
               addr_in = addr_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
            end
         end else begin
            col_in  = col_ff + {{(COL_W-1){1'b0}}, 1'b1};
            addr_in = addr_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
         end
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      byp_valid_in = byp_valid_ff;
      if (req_fire) begin
         s1_valid_in  = 1'b1;
         byp_valid_in = s1_fire && (s1_addr_ff == addr_ff);
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   // Report count of the current frame; frame_end clears it after its own pixel.
   always_comb begin
      reports_in = reports_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            reports_in = '0;
         end else if (report) begin
            reports_in = reports_ff + {{(REPORT_W-1){1'b0}}, 1'b1};
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         rsp_valid_in = report;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         addr_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
         reports_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         addr_ff      <= addr_in;
         s1_valid_ff  <= s1_valid_in;
         byp_valid_ff <= byp_valid_in;
         reports_ff   <= reports_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_addr_ff  <= addr_ff;
         s1_last_ff  <= req_port.frame_end;
         s1_hit_ff   <= dcpd_match(req_port.hue, req_port.saturation,
                                   req_port.brightness, cfg);
         byp_data_ff <= new_entry;
      end
      if (s1_fire && report) begin
         rsp_col_ff <= COORD_W'(s1_col_ff);
         rsp_row_ff <= COORD_W'(s1_row_ff);
         rsp_num_ff <= reports_ff;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.pixel_col     = rsp_col_ff;
   assign rsp_port.pixel_row     = rsp_row_ff;
   assign rsp_port.report_number = rsp_num_ff;

endmodule

/* rtl/dcpd_csr.sv */
// Configuration register bank of the debounced color pixel detector.
module dcpd_csr (
   input  logic                  clock,
   input  logic                  reset,
   dcpd_csr_if.sink              csr_port,
   output dcpd_pkg::dcpd_cfg_type cfg
);
   import dcpd_pkg::*;

   dcpd_cfg_type cfg_ff;
   dcpd_cfg_type cfg_in;

   assign csr_port.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            CSR_HUE_LOW_A:      cfg_in.hue_low_a      = csr_port.data;
            CSR_HUE_HIGH_A:     cfg_in.hue_high_a     = csr_port.data;
            CSR_HUE_LOW_B:      cfg_in.hue_low_b      = csr_port.data;
            CSR_HUE_HIGH_B:     cfg_in.hue_high_b     = csr_port.data;
            CSR_SAT_MIN:        cfg_in.sat_min        = csr_port.data;
            CSR_VAL_MIN:        cfg_in.val_min        = csr_port.data;
            CSR_DEBOUNCE_LIMIT: cfg_in.debounce_limit = csr_port.data[LIMIT_W-1:0];
            CSR_MAX_REPORTS:    cfg_in.max_reports    = csr_port.data[REPORT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hue_low_a      <= RST_HUE_LOW_A;
         cfg_ff.hue_high_a     <= RST_HUE_HIGH_A;
         cfg_ff.hue_low_b      <= RST_HUE_LOW_B;
         cfg_ff.hue_high_b     <= RST_HUE_HIGH_B;
         cfg_ff.sat_min        <= RST_SAT_MIN;
         cfg_ff.val_min        <= RST_VAL_MIN;
         cfg_ff.debounce_limit <= RST_DEBOUNCE_LIMIT;
         cfg_ff.max_reports    <= RST_MAX_REPORTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/dcpd_ram.sv */
// Simple dual-port memory with one write port and one registered read port.
module dcpd_ram #(
   parameter int DEPTH  = dcpd_pkg::DCPD_FRAME_WIDTH * dcpd_pkg::DCPD_FRAME_HEIGHT,
   parameter int DATA_W = dcpd_pkg::ENTRY_W,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read before write: a read of the entry written at the same edge returns the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
